// ===== src/palette_color_matrix_top_macros.svh =====
// Assertion macros shared by the checker of the palette color matrix.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PALETTE_COLOR_MATRIX_TOP_MACROS_SVH
`define PALETTE_COLOR_MATRIX_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pcm_pkg.sv =====
// Shared widths and register indexes of the palette color matrix.
// No dependencies; used by the top level, its checker and the testbench.
`default_nettype none

package pcm_pkg;

	localparam int COLOR_W   = 8;
	localparam int COEF_W    = 16;
	localparam int CFG_W     = 4 * COEF_W;
	localparam int CFG_IDX_W = 2;
	// 16-bit weight times 9-bit value, four terms summed.
	localparam int ACC_W     = COEF_W + COLOR_W + 1 + 2;

	localparam logic [CFG_IDX_W-1:0] REG_RED_COL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_COL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_COL  = 2'd2;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [CFG_W-1:0]   column_t;

endpackage

`default_nettype wire

// ===== src/palette_color_matrix_top.sv =====
// Pipeline: an input register and then a result register lie between input and result.
// Throughput: one color per cycle while out_ready holds; the output and input registers
// form a two-deep pipeline: an empty input register takes a color while a result waits.
// Reset: arst_n clears both pipeline valid bits and loads the identity matrix
// into the three column registers.
`default_nettype none

module palette_color_matrix_top #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [pcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [pcm_pkg::CFG_W-1:0]       cfg_data,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire [pcm_pkg::COLOR_W-1:0]     red_in,
	input  wire [pcm_pkg::COLOR_W-1:0]     green_in,
	input  wire [pcm_pkg::COLOR_W-1:0]     blue_in,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [pcm_pkg::COLOR_W-1:0]    red_out,
	output logic [pcm_pkg::COLOR_W-1:0]    green_out,
	output logic [pcm_pkg::COLOR_W-1:0]    blue_out
);

	localparam int CW = pcm_pkg::COEF_W;
	localparam int AW = pcm_pkg::ACC_W;
	localparam int DW = pcm_pkg::COLOR_W;
	localparam logic [pcm_pkg::CFG_W-1:0] ONE = pcm_pkg::CFG_W'(1) << COEF_FRAC_BITS;

	pcm_pkg::column_t red_col_q, green_col_q, blue_col_q;

	logic           valid_s1, valid_s2;
	pcm_pkg::color_t red_s1, green_s1, blue_s1;
	pcm_pkg::color_t red_s2, green_s2, blue_s2;
	logic           adv_s2;
	pcm_pkg::color_t red_nxt, green_nxt, blue_nxt;

	function automatic logic signed [AW-1:0] term(input logic [CW-1:0] w,
		input logic [DW:0] v);
		logic signed [AW-1:0] ws, vs;
		ws = AW'($signed(w));
		vs = AW'($signed(v));
		return ws * vs;
	endfunction

	function automatic pcm_pkg::color_t channel(input pcm_pkg::column_t col,
		input pcm_pkg::color_t r, input pcm_pkg::color_t g, input pcm_pkg::color_t b);
		logic signed [AW-1:0] acc;
		pcm_pkg::color_t res;
		acc = term(col[CW-1:0], {1'b0, r})
			+ term(col[2*CW-1:CW], {1'b0, g})
			+ term(col[3*CW-1:2*CW], {1'b0, b})
			+ term(col[4*CW-1:3*CW], {1'b0, {DW{1'b1}}});
		// Negative sums clamp to zero; any bit above the 8-bit result saturates.
		if (acc[AW-1])
			res = '0;
		else if (|acc[AW-2:COEF_FRAC_BITS+DW])
			res = '1;
		else
			res = acc[COEF_FRAC_BITS+DW-1:COEF_FRAC_BITS];
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_col_q   <= ONE;
			green_col_q <= ONE << CW;
			blue_col_q  <= ONE << (2 * CW);
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcm_pkg::REG_RED_COL:   red_col_q   <= cfg_data;
				pcm_pkg::REG_GREEN_COL: green_col_q <= cfg_data;
				pcm_pkg::REG_BLUE_COL:  blue_col_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
		end
	end

	always_comb begin
		red_nxt   = channel(red_col_q, red_s1, green_s1, blue_s1);
		green_nxt = channel(green_col_q, red_s1, green_s1, blue_s1);
		blue_nxt  = channel(blue_col_q, red_s1, green_s1, blue_s1);
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			red_s2   <= red_nxt;
			green_s2 <= green_nxt;
			blue_s2  <= blue_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign red_out   = red_s2;
	assign green_out = green_s2;
	assign blue_out  = blue_s2;

endmodule

`default_nettype wire

// ===== src/pcm_checker.sv =====
// Port-level checker for the palette color matrix, bound to the top level.
// Depends on pcm_pkg and the assertion macros header.
`default_nettype none
`include "palette_color_matrix_top_macros.svh"

module pcm_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [pcm_pkg::COLOR_W-1:0] red_out,
	input wire [pcm_pkg::COLOR_W-1:0] green_out,
	input wire [pcm_pkg::COLOR_W-1:0] blue_out
);

	// A stalled result must hold until the transaction completes.
	`PCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out),
		"result changed while stalled")

	// With the output register empty, the pipeline always has room.
	`PCM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
		"input not ready while output register empty")

	// A color taken while the output is empty sets out_valid after the input and result registers.
	`PCM_ASSERT_NOW(a_latency, in_valid && in_ready && !out_valid, ##2 out_valid,
		"result missing two cycles after transaction")

endmodule

bind palette_color_matrix_top pcm_checker u_pcm_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for palette_color_matrix_top: the 3x4 color matrix on 8-bit RGB.
// It predicts each transformed color and compares it with the block's output.
// Depends on pcm_pkg and palette_color_matrix_top.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

	localparam int COEF_FRAC = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [pcm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [pcm_pkg::COEF_W-1:0] WEIGHT_ONE = pcm_pkg::COEF_W'(1 << COEF_FRAC);

	typedef struct packed {
		pcm_pkg::color_t red;
		pcm_pkg::color_t green;
		pcm_pkg::color_t blue;
	} rgb_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pcm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pcm_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [pcm_pkg::COLOR_W-1:0] red_in;
	logic [pcm_pkg::COLOR_W-1:0] green_in;
	logic [pcm_pkg::COLOR_W-1:0] blue_in;
	logic out_valid;
	logic out_ready;
	logic [pcm_pkg::COLOR_W-1:0] red_out;
	logic [pcm_pkg::COLOR_W-1:0] green_out;
	logic [pcm_pkg::COLOR_W-1:0] blue_out;

	// Matrix columns as the block should hold them, indexed by register.
	pcm_pkg::column_t matrix_col [0:2];
	rgb_t pending_colors[$];
	int errors = 0;
	int colors_sent;
	int matrix_writes;
	int cycle_count = 0;
	bit sender_gaps;
	bit receiver_stalls;

	palette_color_matrix_top #(
		.COEF_FRAC_BITS(COEF_FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic pcm_pkg::column_t pack_weights(logic [pcm_pkg::COEF_W-1:0] wr,
			logic [pcm_pkg::COEF_W-1:0] wg, logic [pcm_pkg::COEF_W-1:0] wb,
			logic [pcm_pkg::COEF_W-1:0] wo);
		return {wo, wb, wg, wr};
	endfunction

	// One output channel: signed weighted sum with the offset scaled to 255, then clamped.
	function automatic pcm_pkg::color_t mix_channel(pcm_pkg::column_t col, pcm_pkg::color_t r,
			pcm_pkg::color_t g, pcm_pkg::color_t b);
		longint acc;
		longint q;
		acc = longint'($signed(col[15:0])) * longint'(r)
			+ longint'($signed(col[31:16])) * longint'(g)
			+ longint'($signed(col[47:32])) * longint'(b)
			+ longint'($signed(col[63:48])) * 255;
		if (acc < 0)
			return '0;
		q = acc >>> COEF_FRAC;
		if (q > 255)
			return 8'hFF;
		return pcm_pkg::color_t'(q);
	endfunction

	function automatic rgb_t transform_color(pcm_pkg::color_t r, pcm_pkg::color_t g,
			pcm_pkg::color_t b);
		rgb_t c;
		c.red = mix_channel(matrix_col[0], r, g, b);
		c.green = mix_channel(matrix_col[1], r, g, b);
		c.blue = mix_channel(matrix_col[2], r, g, b);
		return c;
	endfunction

	// Mostly weights within about +-1.5 so the outputs land mid-range; some raw bit patterns.
	function automatic pcm_pkg::column_t random_column();
		logic [pcm_pkg::COEF_W-1:0] w [0:3];
		int v;
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				w[i] = pcm_pkg::COEF_W'($urandom);
			end else begin
				v = int'($urandom_range(0, 12288)) - 6144;
				if (i == 3)
					v = v / 4;
				w[i] = v[pcm_pkg::COEF_W-1:0];
			end
		end
		return pack_weights(w[0], w[1], w[2], w[3]);
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_color(input pcm_pkg::color_t r, input pcm_pkg::color_t g,
			input pcm_pkg::color_t b);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do
			@(posedge clk);
		while (!in_ready);
		pending_colors.push_back(transform_color(r, g, b));
		colors_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The enable drops for one cycle after every write.
	task automatic write_column(input logic [pcm_pkg::CFG_IDX_W-1:0] idx,
			input pcm_pkg::column_t value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx != REG_UNUSED)
			matrix_col[idx] = value;
		matrix_writes++;
		@(negedge clk);
	endtask

	task automatic send_random_colors(input int count);
		for (int n = 0; n < count; n++)
			send_color(pcm_pkg::color_t'($urandom), pcm_pkg::color_t'($urandom),
				pcm_pkg::color_t'($urandom));
	endtask

	task automatic test_identity();
		send_color(8'h00, 8'h00, 8'h00);
		send_color(8'hFF, 8'hFF, 8'hFF);
		send_color(8'hFF, 8'h00, 8'h00);
		send_color(8'h00, 8'hFF, 8'h00);
		send_color(8'h00, 8'h00, 8'hFF);
		send_color(8'h55, 8'hAA, 8'h5A);
		send_color(8'hAA, 8'h55, 8'hA5);
		drain_pipeline();
	endtask

	task automatic test_clamping();
		// Negative red weight gives a negative sum; green has half offset to push past 255.
		write_column(pcm_pkg::REG_RED_COL,
			pack_weights(16'hF000, 16'h0000, 16'h0000, 16'h0000));
		write_column(pcm_pkg::REG_GREEN_COL,
			pack_weights(16'h0000, WEIGHT_ONE, 16'h0000, 16'h0800));
		write_column(pcm_pkg::REG_BLUE_COL, {4{16'h7FFF}});
		send_color(8'h00, 8'h00, 8'h00);
		send_color(8'h01, 8'h80, 8'h00);
		send_color(8'hFF, 8'hC8, 8'hFF);
		send_color(8'h10, 8'h7F, 8'h01);
		drain_pipeline();
		// Most negative weights everywhere, all-zero column, and exact 255 boundary on blue.
		write_column(pcm_pkg::REG_RED_COL, {4{16'h8000}});
		write_column(pcm_pkg::REG_GREEN_COL, '0);
		write_column(pcm_pkg::REG_BLUE_COL,
			pack_weights(16'h0000, 16'h0000, WEIGHT_ONE, 16'h0010));
		send_color(8'h00, 8'h00, 8'h00);
		send_color(8'hFF, 8'hFF, 8'hFF);
		send_color(8'h80, 8'h40, 8'hF0);
		drain_pipeline();
		// A write past the last register must leave the matrix alone.
		write_column(pcm_pkg::REG_RED_COL,
			pack_weights(WEIGHT_ONE, 16'h0000, 16'h0000, 16'h0000));
		write_column(pcm_pkg::REG_GREEN_COL,
			pack_weights(16'h0000, WEIGHT_ONE, 16'h0000, 16'h0000));
		write_column(pcm_pkg::REG_BLUE_COL,
			pack_weights(16'h0000, 16'h0000, WEIGHT_ONE, 16'h0000));
		write_column(REG_UNUSED, {4{16'h8000}});
		send_color(8'h12, 8'h34, 8'h56);
		send_color(8'hFE, 8'h01, 8'h80);
		drain_pipeline();
	endtask

	task automatic test_random_matrices();
		for (int p = 0; p < 6; p++) begin
			write_column(pcm_pkg::REG_RED_COL,
				p == 5 ? pcm_pkg::column_t'({$urandom, $urandom}) : random_column());
			write_column(pcm_pkg::REG_GREEN_COL, random_column());
			write_column(pcm_pkg::REG_BLUE_COL, random_column());
			if (p == 3)
				write_column(REG_UNUSED, {$urandom, $urandom});
			send_random_colors(125);
			// Hold the sender until the block has handed over everything.
			if (p == 1)
				drain_pipeline();
			send_random_colors(125);
			drain_pipeline();
		end
	endtask

	task automatic test_streaming();
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		write_column(pcm_pkg::REG_RED_COL, random_column());
		write_column(pcm_pkg::REG_GREEN_COL, random_column());
		write_column(pcm_pkg::REG_BLUE_COL, random_column());
		send_random_colors(400);
		drain_pipeline();
	endtask

	// Output stalls come in bursts of random length while receiver_stalls is set.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_colors.size() == 0) begin
				$error("unexpected result transaction: %0d %0d %0d", red_out, green_out,
					blue_out);
				errors++;
			end else begin
				want = pending_colors.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, red_out);
					errors++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, green_out);
					errors++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		colors_sent = 0;
		matrix_writes = 0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		matrix_col[0] = pcm_pkg::column_t'(WEIGHT_ONE);
		matrix_col[1] = pcm_pkg::column_t'(WEIGHT_ONE) << pcm_pkg::COEF_W;
		matrix_col[2] = pcm_pkg::column_t'(WEIGHT_ONE) << (2 * pcm_pkg::COEF_W);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_identity();
		test_clamping();
		test_random_matrices();
		test_streaming();

		$display("Sent %0d colors through %0d register writes: identity, clamping at both ends,",
			colors_sent, matrix_writes);
		$display("ignored register index, random matrices with stalls, and a back-to-back stream.");
		if (errors == 0 && pending_colors.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/pcm_pkg.sv
src/palette_color_matrix_top.sv
src/pcm_checker.sv
tb/sv/tb_top.sv
